// File: hw/rtl/lcg_pkg.sv
package lcg_pkg;

	// Counts cover the full parameter range (list and choose sizes up to 64).
	localparam int CNT_W = 7;
	localparam int REG_W = 5;
	localparam int VAL_W = 32;
	localparam int POS_W = 4;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [REG_W-1:0] reg_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_NEXT = 1'b1;

	localparam logic REG_LIST_LEN = 1'b0;
	localparam logic REG_CHOOSE   = 1'b1;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INIT,
		OP_START,
		OP_SEEK,
		OP_FILL,
		OP_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		cnt_t     k;
		cnt_t     limit;
	} cell_ctl_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic busy;
	} cell_stat_t;

endpackage

// File: hw/rtl/lcg_ram.sv
module lcg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/lcg_cell.sv
module lcg_cell
	import lcg_pkg::*;
#(
	parameter int IDX    = 0,
	parameter int SLOT_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [SLOT_W-1:0] head_slot,
	input  logic [SLOT_W-1:0] right_slot,
	input  logic [SLOT_W-1:0] left_slot,
	input  logic              seek_in,
	input  logic              fill_in,
	output logic [SLOT_W-1:0] slot,
	output logic [SLOT_W-1:0] slot_next,
	output logic              seek_out,
	output logic              fill_out,
	output cell_stat_t        stat
);

	localparam cnt_t POS   = CNT_W'(IDX);
	localparam bit   FIRST = (IDX == 0);

	logic [SLOT_W-1:0] slot_q, slot_d;
	logic              seek_q, seek_d;
	logic              fill_q, fill_d;
	logic              act, is_last, at_max;

	assign act     = POS < ctl.k;
	assign is_last = (POS + CNT_W'(1)) == ctl.k;
	// slot already at its highest legal value for this position
	assign at_max  = CNT_W'(slot_q) == (ctl.limit + POS);

	always_comb begin
		slot_d    = slot_q;
		seek_d    = seek_q;
		fill_d    = fill_q;
		seek_out  = 1'b0;
		fill_out  = 1'b0;
		stat.hit  = 1'b0;
		stat.miss = 1'b0;
		stat.busy = fill_q;
		unique case (ctl.op)
			OP_HOLD: begin
			end
			OP_INIT: begin
				slot_d = SLOT_W'(IDX);
				seek_d = 1'b0;
				fill_d = 1'b0;
			end
			OP_START: begin
				seek_d = is_last;
				fill_d = 1'b0;
			end
			OP_SEEK: begin
				seek_d = seek_in;
				fill_d = fill_in;
				if (seek_q) begin
					if (!at_max) begin
						slot_d   = slot_q + SLOT_W'(1);
						stat.hit = 1'b1;
						fill_out = !is_last;
					end else if (FIRST) begin
						stat.miss = 1'b1;
					end else begin
						seek_out = 1'b1;
					end
				end
			end
			OP_FILL: begin
				fill_d = fill_in;
				if (fill_q) begin
					slot_d   = left_slot + SLOT_W'(1);
					fill_out = !is_last;
				end
			end
			OP_ROT: begin
				if (act) begin
					slot_d = is_last ? head_slot : right_slot;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			seek_q <= 1'b0;
			fill_q <= 1'b0;
		end else begin
			slot_q <= slot_d;
			seek_q <= seek_d;
			fill_q <= fill_d;
		end
	end

	assign slot      = slot_q;
	assign slot_next = slot_d;

endmodule

// File: hw/rtl/lex_combination_generator_top.sv
// Lexicographic k-combination generator. Load requests (command 0) write one list slot and
// restart the enumeration; next requests (command 1) return the k elements of the following
// combination, lowest slot first, with last set on the final one, or a single exhausted
// result (found 0) once none remain; with k of 0 the first next request returns one empty
// combination. n and k are to be set through the register port only while the block is idle;
// the block does not enforce this. The current combination lives in a row of MAX_CHOOSE
// cells, one slot index per cell. For a later next request, a search token walks left one
// cell per cycle from the last cell to the leftmost position that changes, a refill token
// then walks right one cell per cycle, and the elements then leave one per cycle, while the
// output is not stalled, through the single read port of the list memory.
module lex_combination_generator_top
	import lcg_pkg::*;
#(
	parameter int MAX_LIST   = 16,
	parameter int MAX_CHOOSE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [3:0]         load_index,
	input  logic signed [31:0] load_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] elem_value,
	output logic [3:0]         elem_position,
	output logic               found,
	output logic               empty_comb,
	output logic               last
);

	localparam int SLOT_W = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEEK,
		S_FILL,
		S_EMIT,
		S_ONE
	} state_t;

	state_t            state_q;
	reg_t              n_q, k_q;
	logic              started_q, exhausted_q;
	logic              one_found_q, one_empty_q;
	cnt_t              cnt_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  elem_value_q;
	logic [POS_W-1:0]  elem_position_q;
	logic              found_q, empty_comb_q, last_q;

	cnt_t              n_eff, k_eff;
	logic              k_gt_n;
	logic              cfg_wr, in_take, out_load, ram_we;
	logic [VAL_W-1:0]  rd_data;
	cell_ctl_t         ctl;

	logic [SLOT_W-1:0] slot_w      [MAX_CHOOSE];
	logic [SLOT_W-1:0] slot_next_w [MAX_CHOOSE];
	logic              seek_w      [MAX_CHOOSE];
	logic              fill_w      [MAX_CHOOSE];
	cell_stat_t        stat_w      [MAX_CHOOSE];
	logic [MAX_CHOOSE-1:0] hit_v, miss_v, busy_v;
	logic              hit_any, miss_any, fill_any;

	assign n_eff  = (CNT_W'(n_q) > CNT_W'(MAX_LIST)) ? CNT_W'(MAX_LIST) : CNT_W'(n_q);
	assign k_eff  = (CNT_W'(k_q) > CNT_W'(MAX_CHOOSE)) ? CNT_W'(MAX_CHOOSE) : CNT_W'(k_q);
	assign k_gt_n = k_eff > n_eff;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign in_stall = state_q != S_IDLE;
	assign in_take  = in_valid && (state_q == S_IDLE);
	assign out_load = !out_valid_q || !out_stall;
	assign ram_we   = in_take && (command == CMD_LOAD) && (32'(load_index) < MAX_LIST);

	always_comb begin
		unique case (paddr[2])
			REG_LIST_LEN: prdata = 32'(n_q);
			REG_CHOOSE:   prdata = 32'(k_q);
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		ctl.k     = k_eff;
		ctl.limit = n_eff - k_eff;
		ctl.op    = OP_HOLD;
		unique case (state_q)
			S_IDLE: begin
				if (in_take && (command == CMD_NEXT) && !exhausted_q) begin
					if (!started_q) begin
						if (!k_gt_n) begin
							ctl.op = OP_INIT;
						end
					end else if ((k_eff != '0) && !k_gt_n) begin
						ctl.op = OP_START;
					end
				end
			end
			S_SEEK: ctl.op = OP_SEEK;
			S_FILL: ctl.op = fill_any ? OP_FILL : OP_HOLD;
			S_EMIT: ctl.op = out_load ? OP_ROT : OP_HOLD;
			S_ONE:  ctl.op = OP_HOLD;
			default: ctl.op = OP_HOLD;
		endcase
	end

	for (genvar gi = 0; gi < MAX_CHOOSE; gi++) begin : g_cell
		logic [SLOT_W-1:0] right_slot, left_slot;
		logic              seek_in, fill_in;

		if (gi == MAX_CHOOSE - 1) begin : g_tail
			assign right_slot = '0;
			assign seek_in    = 1'b0;
		end else begin : g_body
			assign right_slot = slot_w[gi+1];
			assign seek_in    = seek_w[gi+1];
		end

		if (gi == 0) begin : g_head
			assign left_slot = '0;
			assign fill_in   = 1'b0;
		end else begin : g_rest
			assign left_slot = slot_w[gi-1];
			assign fill_in   = fill_w[gi-1];
		end

		lcg_cell #(
			.IDX    (gi),
			.SLOT_W (SLOT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.head_slot  (slot_w[0]),
			.right_slot (right_slot),
			.left_slot  (left_slot),
			.seek_in    (seek_in),
			.fill_in    (fill_in),
			.slot       (slot_w[gi]),
			.slot_next  (slot_next_w[gi]),
			.seek_out   (seek_w[gi]),
			.fill_out   (fill_w[gi]),
			.stat       (stat_w[gi])
		);

		assign hit_v[gi]  = stat_w[gi].hit;
		assign miss_v[gi] = stat_w[gi].miss;
		assign busy_v[gi] = stat_w[gi].busy;
	end

	assign hit_any  = |hit_v;
	assign miss_any = |miss_v;
	assign fill_any = |busy_v;

	// read address follows the head cell's next slot so data lines up with the head
	lcg_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_LIST)
	) u_list (
		.clk   (clk),
		.we    (ram_we),
		.waddr (SLOT_W'(load_index)),
		.wdata (load_value),
		.raddr (slot_next_w[0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			n_q             <= '0;
			k_q             <= '0;
			started_q       <= 1'b0;
			exhausted_q     <= 1'b0;
			one_found_q     <= 1'b0;
			one_empty_q     <= 1'b0;
			cnt_q           <= '0;
			out_valid_q     <= 1'b0;
			elem_value_q    <= '0;
			elem_position_q <= '0;
			found_q         <= 1'b0;
			empty_comb_q    <= 1'b0;
			last_q          <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_LIST_LEN: n_q <= pwdata[REG_W-1:0];
					REG_CHOOSE:   k_q <= pwdata[REG_W-1:0];
					default: begin
					end
				endcase
				started_q   <= 1'b0;
				exhausted_q <= 1'b0;
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (command == CMD_LOAD) begin
							started_q   <= 1'b0;
							exhausted_q <= 1'b0;
						end else if (exhausted_q) begin
							one_found_q <= 1'b0;
							one_empty_q <= 1'b0;
							state_q     <= S_ONE;
						end else if (!started_q) begin
							started_q <= 1'b1;
							if (k_gt_n) begin
								exhausted_q <= 1'b1;
								one_found_q <= 1'b0;
								one_empty_q <= 1'b0;
								state_q     <= S_ONE;
							end else if (k_eff == '0) begin
								one_found_q <= 1'b1;
								one_empty_q <= 1'b1;
								state_q     <= S_ONE;
							end else begin
								cnt_q   <= k_eff;
								state_q <= S_EMIT;
							end
						end else if ((k_eff == '0) || k_gt_n) begin
							exhausted_q <= 1'b1;
							one_found_q <= 1'b0;
							one_empty_q <= 1'b0;
							state_q     <= S_ONE;
						end else begin
							state_q <= S_SEEK;
						end
					end
				end
				S_SEEK: begin
					if (miss_any) begin
						exhausted_q <= 1'b1;
						one_found_q <= 1'b0;
						one_empty_q <= 1'b0;
						state_q     <= S_ONE;
					end else if (hit_any) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (!fill_any) begin
						cnt_q   <= k_eff;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						out_valid_q     <= 1'b1;
						elem_value_q    <= rd_data;
						elem_position_q <= POS_W'(slot_w[0]);
						found_q         <= 1'b1;
						empty_comb_q    <= 1'b0;
						last_q          <= cnt_q == CNT_W'(1);
						cnt_q           <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ONE: begin
					if (out_load) begin
						out_valid_q     <= 1'b1;
						elem_value_q    <= '0;
						elem_position_q <= '0;
						found_q         <= one_found_q;
						empty_comb_q    <= one_empty_q;
						last_q          <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign elem_value    = elem_value_q;
	assign elem_position = elem_position_q;
	assign found         = found_q;
	assign empty_comb    = empty_comb_q;
	assign last          = last_q;

endmodule

// File: verif/lex_combination_generator_top_tb.sv
module lex_combination_generator_top_tb;
	import lcg_pkg::*;

	localparam int NUM_SLOTS = 16;

	typedef struct packed {
		logic signed [31:0] value;
		logic [3:0]         pos;
		logic               found;
		logic               empty;
		logic               last;
	} elem_t;

	class comb_tracker;
		elem_t       expected_elems[$];
		logic [31:0] slot_vals[NUM_SLOTS];
		logic [3:0]  chosen[NUM_SLOTS];
		bit          started;
		bit          done;
		logic [4:0]  len_reg;
		logic [4:0]  choose_reg;
		int          errors;

		function new();
			errors = 0;
			started = 0;
			done = 0;
			len_reg = '0;
			choose_reg = '0;
			foreach (chosen[i]) chosen[i] = '0;
			foreach (slot_vals[i]) slot_vals[i] = '0;
		endfunction

		function void queue_elem(elem_t e);
			expected_elems.insert(expected_elems.size(), e);
		endfunction

		function void write_reg(logic idx, logic [4:0] val);
			if (idx == REG_LIST_LEN) begin
				len_reg = val;
			end else begin
				choose_reg = val;
			end
			started = 0;
			done = 0;
		endfunction

		function bit step_forward(int n, int k);
			int j;
			for (int i = k; i > 0; i--) begin
				j = i - 1;
				if (int'(chosen[j]) < n - k + j) begin
					chosen[j] = chosen[j] + 4'd1;
					for (int m = j + 1; m < k; m++) chosen[m] = chosen[m-1] + 4'd1;
					return 1;
				end
			end
			return 0;
		endfunction

		function void note_request(logic cmd, logic [3:0] idx, logic [31:0] val);
			int    n;
			int    k;
			elem_t e;
			if (cmd == CMD_LOAD) begin
				slot_vals[idx] = val;
				started = 0;
				done = 0;
				return;
			end
			n = (len_reg > NUM_SLOTS) ? NUM_SLOTS : int'(len_reg);
			k = (choose_reg > NUM_SLOTS) ? NUM_SLOTS : int'(choose_reg);
			if (!done) begin
				if (!started) begin
					started = 1;
					if (k > n) begin
						done = 1;
					end else begin
						for (int i = 0; i < k; i++) chosen[i] = 4'(i);
					end
				end else if (k == 0 || k > n || !step_forward(n, k)) begin
					done = 1;
				end
			end
			if (done) begin
				e = '{value: '0, pos: '0, found: 1'b0, empty: 1'b0, last: 1'b1};
				queue_elem(e);
			end else if (k == 0) begin
				e = '{value: '0, pos: '0, found: 1'b1, empty: 1'b1, last: 1'b1};
				queue_elem(e);
			end else begin
				for (int i = 0; i < k; i++) begin
					e.value = slot_vals[chosen[i]];
					e.pos = chosen[i];
					e.found = 1'b1;
					e.empty = 1'b0;
					e.last = (i == k - 1);
					queue_elem(e);
				end
			end
		endfunction

		function void check_elem(elem_t got);
			elem_t want;
			if (expected_elems.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: unexpected element: value %0d pos %0d found %0b empty %0b last %0b",
						$time, got.value, got.pos, got.found, got.empty, got.last);
				return;
			end
			want = expected_elems.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 40)
					$display({"%0t: mismatch: expected value %0d pos %0d found %0b empty %0b last %0b,",
						" got value %0d pos %0d found %0b empty %0b last %0b"}, $time,
						want.value, want.pos, want.found, want.empty, want.last,
						got.value, got.pos, got.found, got.empty, got.last);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               command;
	logic [3:0]         load_index;
	logic signed [31:0] load_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] elem_value;
	logic [3:0]         elem_position;
	logic               found;
	logic               empty_comb;
	logic               last;

	comb_tracker          sb;
	int                   idle_pct = 30;
	int                   stall_pct = 30;
	logic                 hold_req;
	int                   hold_left = 0;
	bit [NUM_SLOTS-1:0]   slot_written = '0;
	int                   items_sent = 0;

	lex_combination_generator_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.load_index   (load_index),
		.load_value   (load_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.elem_value   (elem_value),
		.elem_position(elem_position),
		.found        (found),
		.empty_comb   (empty_comb),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_elem(elem_t'{elem_value, elem_position, found, empty_comb, last});
		if (hold_req) begin
			hold_left = 300;
			hold_req <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic reg_write(logic idx, logic [4:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {27'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic send_item(logic cmd, logic [3:0] idx, logic [31:0] val);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		load_index <= idx;
		load_value <= val;
		do @(posedge clk); while (in_stall);
		sb.note_request(cmd, idx, val);
		if (cmd == CMD_LOAD) slot_written[idx] = 1'b1;
		items_sent++;
	endtask

	task automatic run_nexts(int count);
		repeat (count) send_item(CMD_NEXT, 4'($urandom), $urandom);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_elems.size() != 0);
	endtask

	task automatic wait_idle();
		drain_results();
		repeat (60) @(posedge clk);
	endtask

	// every slot the enumeration can read gets written before any next request
	task automatic setup_phase(logic [4:0] n, logic [4:0] k);
		int lim;
		wait_idle();
		reg_write(REG_LIST_LEN, n);
		reg_write(REG_CHOOSE, k);
		lim = (n > NUM_SLOTS) ? NUM_SLOTS : int'(n);
		for (int i = 0; i < lim; i++)
			if (!slot_written[i]) send_item(CMD_LOAD, 4'(i), $urandom);
	endtask

	initial begin
		int         ph;
		int         sel;
		int         cnt;
		logic [4:0] n;
		logic [4:0] k;

		sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		command <= CMD_LOAD;
		load_index <= '0;
		load_value <= '0;
		hold_req <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty combination, then exhausted
		setup_phase(5'd0, 5'd0);
		run_nexts(2);
		// k above n
		setup_phase(5'd0, 5'd3);
		run_nexts(1);
		send_item(CMD_LOAD, 4'd0, 32'h8000_0000);
		send_item(CMD_LOAD, 4'd1, 32'h7fff_ffff);
		send_item(CMD_LOAD, 4'd2, 32'h0000_0000);
		send_item(CMD_LOAD, 4'd3, 32'hffff_ffff);
		setup_phase(5'd4, 5'd2);
		run_nexts(3);
		// load restarts the enumeration
		send_item(CMD_LOAD, 4'd15, 32'h5a5a_a5a5);
		run_nexts(8);
		// oversized registers
		setup_phase(5'd31, 5'd31);
		run_nexts(2);

		ph = 0;
		while (items_sent < 410) begin
			sel = $urandom_range(9);
			if (sel == 0) begin
				n = 5'($urandom_range(16, 31));
				k = 5'($urandom_range(0, 31));
			end else if (sel == 1) begin
				n = 5'($urandom_range(0, 16));
				k = 5'($urandom_range(0, 31));
			end else begin
				n = 5'($urandom_range(1, 8));
				k = 5'($urandom_range(0, n));
			end
			cnt = $urandom_range(4, 20);
			if (ph == 2) begin
				n = 5'd16;
				k = 5'd8;
				cnt = 12;
			end
			setup_phase(n, k);
			if (ph == 2) begin
				idle_pct = 0;
				hold_req <= 1'b1;
			end else if (ph == 4) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				idle_pct = 30;
				stall_pct = 30;
			end
			for (int c = 0; c < cnt; c++) begin
				if (c == cnt / 2 && $urandom_range(3) == 0) drain_results();
				if ($urandom_range(99) < 8)
					send_item(CMD_LOAD, 4'($urandom), $urandom);
				else
					send_item(CMD_NEXT, 4'($urandom), $urandom);
			end
			ph++;
		end

		wait_idle();
		if (sb.expected_elems.size() != 0) sb.errors++;
		if (sb.errors == 0) begin
			$display("[lex_combination_generator_top] OK");
		end else begin
			$display("[lex_combination_generator_top] ERROR");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("[lex_combination_generator_top] ERROR");
		$finish;
	end

endmodule
